[design/dadpwm_pkg.sv]
`default_nettype none
package dadpwm_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SETPOINT_X    = 3'd0;
  localparam logic [2:0] REG_SETPOINT_Y    = 3'd1;
  localparam logic [2:0] REG_DEADBAND      = 3'd2;
  localparam logic [2:0] REG_MAX_DUTY      = 3'd3;
  localparam logic [2:0] REG_MIN_DUTY      = 3'd4;
  localparam logic [2:0] REG_JOYSTICK_DUTY = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // measured_axis codes
  localparam logic [1:0] MEAS_NONE = 2'd0;
  localparam logic [1:0] MEAS_X    = 2'd1;
  localparam logic [1:0] MEAS_Y    = 2'd2;

  // Stick decode and thresholds
  localparam logic [7:0] STICK_KEY = 8'h17;
  localparam logic [7:0] STICK_HI  = 8'd160;
  localparam logic [7:0] STICK_LO  = 8'd90;

  // Period scaling: period in 1/25 us is count * 27
  localparam logic [20:0] COUNT_MUL = 21'd27;
  localparam logic [14:0] SP_MUL    = 15'd25;
  localparam logic [15:0] BAND_MUL  = 16'd25;

  // Error of 300 us or more already drives duty past any 7-bit clamp
  localparam logic [20:0] ERR_SAT_MAG = 21'd7500;
  // floor(x/25) for x < 7500 and floor(y/20) for y < 2700
  localparam logic [25:0] RECIP_25 = 26'd5243;
  localparam logic [23:0] RECIP_20 = 24'd3277;
  localparam logic [11:0] DUTY_MUL = 12'd9;

  typedef struct packed {
    logic [15:0] period_count;
    logic        joystick_mode;
    logic [7:0]  joy_x_raw;
    logic [7:0]  joy_y_raw;
  } dadpwm_in_t;

  typedef struct packed {
    logic       x_forward;
    logic       x_reverse;
    logic       y_forward;
    logic       y_reverse;
    logic [1:0] measured_axis;
  } dadpwm_out_t;

  typedef struct packed {
    logic [9:0] setpoint;
    logic [7:0] deadband;
    logic [6:0] max_duty;
    logic [6:0] min_duty;
    logic [6:0] joystick_duty;
  } dadpwm_axis_cfg_t;

  // Per-axis work prepared in the first stage
  typedef struct packed {
    logic        joy;
    logic        measure;
    logic        err_sat;
    logic [8:0]  err_us;
    logic [20:0] scaled;
    logic        stick_fwd;
    logic        stick_rev;
  } dadpwm_axis_op_t;

  typedef struct packed {
    logic rev;
    logic fwd;
  } dadpwm_pins_t;

endpackage
`default_nettype wire

[design/dadpwm_axis.sv]
`default_nettype none
module dadpwm_axis import dadpwm_pkg::*; #(
  parameter int TICK_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire dadpwm_axis_op_t   op,
  input  wire logic [TICK_W-1:0] tick,
  input  wire dadpwm_axis_cfg_t  cfg,
  output dadpwm_pins_t           pins
);

  localparam int CMP_W = (TICK_W > 7) ? TICK_W : 7;

  logic [20:0]  scaled_r, scaled_use;
  logic [6:0]   duty_r, duty_nxt, duty_calc, duty_use, duty_joy;
  logic         dir_r, dir_nxt;
  dadpwm_pins_t pins_r, pins_nxt;

  logic [11:0]  nine_e;
  logic [23:0]  d_prod;
  logic [7:0]   d_raw;
  logic [11:0]  lo_us;
  logic [10:0]  hi_us;
  logic [15:0]  lo_u, hi_u;
  logic         below, above, on_loop, on_joy;

  always_comb begin
    nine_e = 12'(op.err_us) * DUTY_MUL;
    d_prod = 24'(nine_e) * RECIP_20;
    d_raw  = d_prod[23:16];
    priority if (op.err_sat || (d_raw > 8'(cfg.max_duty))) begin
      duty_calc = cfg.max_duty;
    end else if (d_raw < 8'(cfg.min_duty)) begin
      duty_calc = 7'd0;
    end else begin
      duty_calc = d_raw[6:0];
    end
  end

  assign duty_use   = op.measure ? duty_calc : duty_r;
  assign scaled_use = op.measure ? op.scaled : scaled_r;

  // Deadband edges in 1/25 us; a negative low edge is never undercut
  always_comb begin
    lo_us = {2'b00, cfg.setpoint} - {4'b0000, cfg.deadband};
    hi_us = {1'b0, cfg.setpoint} + {3'b000, cfg.deadband};
    lo_u  = 16'(lo_us[10:0]) * BAND_MUL;
    hi_u  = 16'(hi_us) * BAND_MUL;
    below = !lo_us[11] && (scaled_use < 21'(lo_u));
    above = scaled_use > 21'(hi_u);
  end

  assign on_loop  = CMP_W'(duty_use) > CMP_W'(tick);
  assign duty_joy = (op.stick_fwd || op.stick_rev) ? cfg.joystick_duty : 7'd0;
  assign on_joy   = CMP_W'(duty_joy) > CMP_W'(tick);

  always_comb begin
    dir_nxt  = dir_r;
    duty_nxt = duty_r;
    pins_nxt = '0;
    if (op.joy) begin
      duty_nxt = duty_joy;
      if (op.stick_fwd) begin
        dir_nxt = 1'b1;
      end else if (op.stick_rev) begin
        dir_nxt = 1'b0;
      end
      // the pin off the current direction holds its level
      if (dir_nxt) begin
        pins_nxt.fwd = on_joy;
        pins_nxt.rev = pins_r.rev;
      end else begin
        pins_nxt.fwd = pins_r.fwd;
        pins_nxt.rev = on_joy;
      end
    end else begin
      duty_nxt = duty_use;
      if (below) begin
        pins_nxt.fwd = on_loop;
      end else if (above) begin
        pins_nxt.rev = on_loop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaled_r <= '0;
      duty_r   <= '0;
      dir_r    <= 1'b0;
      pins_r   <= '0;
    end else if (adv) begin
      scaled_r <= scaled_use;
      duty_r   <= duty_nxt;
      dir_r    <= dir_nxt;
      pins_r   <= pins_nxt;
    end
  end

  assign pins = pins_r;

endmodule
`default_nettype wire

[design/dual_axis_deadband_pwm_drive_unit.sv]
`default_nettype none
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_data   (dadpwm_in_t)
// out_     output     out_valid/out_stall out_data  (dadpwm_out_t)
// cfg_     input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// Two stages: tick advance, stick decode and period error in the first,
// duty, deadband and pin levels in the second, which is also the result.
// Both stages register a beat; one beat enters every cycle unless stalled.
// Synchronous active-low reset clears tick, phase, periods, duties and pins.
// out_stall backs up through both stages to in_stall in the same cycle.
// cfg_ready is always high.
module dual_axis_deadband_pwm_drive_unit import dadpwm_pkg::*; #(
  parameter int PWM_STEPS = 100
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire dadpwm_in_t            in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output dadpwm_out_t                out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TW = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
  localparam logic [TW-1:0] TICK_LAST = TW'(PWM_STEPS - 1);

  logic [9:0] setpoint_x_r, setpoint_y_r;
  logic [7:0] deadband_r;
  logic [6:0] max_duty_r, min_duty_r, joystick_duty_r;

  logic [TW-1:0] tick_r, tick_nxt, tick_s1_r;
  logic          phase_r, phase_nxt;
  logic          s1_valid_r, out_valid_r;
  logic          s1_load, s2_adv;
  logic [1:0]    meas_s1_r, meas_nxt, meas_out_r;
  dadpwm_axis_op_t op_x_r, op_y_r, op_x_nxt, op_y_nxt;

  logic [9:0]  sp_sel;
  logic [20:0] prod, mag;
  logic [14:0] tgt;
  logic [25:0] e_prod;
  logic [7:0]  bx, by;

  dadpwm_axis_cfg_t cfg_x, cfg_y;
  dadpwm_pins_t     pins_x, pins_y;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_x_r    <= 10'd700;
      setpoint_y_r    <= 10'd780;
      deadband_r      <= 8'd10;
      max_duty_r      <= 7'd90;
      min_duty_r      <= 7'd15;
      joystick_duty_r <= 7'd70;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SETPOINT_X:    setpoint_x_r    <= cfg_wdata;
        REG_SETPOINT_Y:    setpoint_y_r    <= cfg_wdata;
        REG_DEADBAND:      deadband_r      <= cfg_wdata[7:0];
        REG_MAX_DUTY:      max_duty_r      <= cfg_wdata[6:0];
        REG_MIN_DUTY:      min_duty_r      <= cfg_wdata[6:0];
        REG_JOYSTICK_DUTY: joystick_duty_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign s2_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_adv;
  assign s1_load  = in_valid && !in_stall;

  // Stage one: tick, phase, period error, stick decode
  always_comb begin
    if (tick_r == TICK_LAST) begin
      tick_nxt  = '0;
      phase_nxt = !phase_r;
    end else begin
      tick_nxt  = tick_r + TW'(1);
      phase_nxt = phase_r;
    end

    sp_sel = phase_nxt ? setpoint_y_r : setpoint_x_r;
    prod   = 21'(in_data.period_count) * COUNT_MUL;
    tgt    = 15'(sp_sel) * SP_MUL;
    if (prod >= 21'(tgt)) begin
      mag = prod - 21'(tgt);
    end else begin
      mag = 21'(tgt) - prod;
    end
    e_prod = 26'(mag[12:0]) * RECIP_25;

    bx = (in_data.joy_x_raw ^ STICK_KEY) + STICK_KEY;
    by = (in_data.joy_y_raw ^ STICK_KEY) + STICK_KEY;

    meas_nxt = MEAS_NONE;
    if (!in_data.joystick_mode && (tick_nxt == '0)) begin
      meas_nxt = phase_nxt ? MEAS_Y : MEAS_X;
    end

    op_x_nxt.joy       = in_data.joystick_mode;
    op_x_nxt.measure   = meas_nxt == MEAS_X;
    op_x_nxt.err_sat   = mag >= ERR_SAT_MAG;
    op_x_nxt.err_us    = e_prod[25:17];
    op_x_nxt.scaled    = prod;
    op_x_nxt.stick_fwd = bx > STICK_HI;
    op_x_nxt.stick_rev = bx < STICK_LO;

    op_y_nxt           = op_x_nxt;
    op_y_nxt.measure   = meas_nxt == MEAS_Y;
    op_y_nxt.stick_fwd = by > STICK_HI;
    op_y_nxt.stick_rev = by < STICK_LO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r     <= '0;
      phase_r    <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        tick_r  <= tick_nxt;
        phase_r <= phase_nxt;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      tick_s1_r <= tick_nxt;
      meas_s1_r <= meas_nxt;
      op_x_r    <= op_x_nxt;
      op_y_r    <= op_y_nxt;
    end
  end

  // Stage two: per-axis duty and pins, held as the result
  always_comb begin
    cfg_x.setpoint      = setpoint_x_r;
    cfg_x.deadband      = deadband_r;
    cfg_x.max_duty      = max_duty_r;
    cfg_x.min_duty      = min_duty_r;
    cfg_x.joystick_duty = joystick_duty_r;
    cfg_y               = cfg_x;
    cfg_y.setpoint      = setpoint_y_r;
  end

  dadpwm_axis #(.TICK_W(TW)) u_axis_x (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (s2_adv),
    .op   (op_x_r),
    .tick (tick_s1_r),
    .cfg  (cfg_x),
    .pins (pins_x)
  );

  dadpwm_axis #(.TICK_W(TW)) u_axis_y (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (s2_adv),
    .op   (op_y_r),
    .tick (tick_s1_r),
    .cfg  (cfg_y),
    .pins (pins_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      meas_out_r <= meas_s1_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_data.x_forward     = pins_x.fwd;
  assign out_data.x_reverse     = pins_x.rev;
  assign out_data.y_forward     = pins_y.fwd;
  assign out_data.y_reverse     = pins_y.rev;
  assign out_data.measured_axis = meas_out_r;

  // Checks
  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r <= TICK_LAST)
    else $error("tick counter past last step");

  a_measure_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (meas_s1_r != MEAS_NONE)) |-> (tick_s1_r == '0))
    else $error("measurement outside counter wrap");

  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $onehot0({op_x_r.measure, op_y_r.measure}))
    else $error("both axes measured on one beat");

  a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room downstream");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_adv |=> out_valid_r)
    else $error("advanced beat not presented");

endmodule
`default_nettype wire
